// ===== rtl/gmfd_pkg.sv =====
`timescale 1ns / 1ps

package gmfd_pkg;

	localparam int PIX_W          = 8;
	localparam int MAG_W          = 8;
	localparam int FRAME_W_W      = 11;
	localparam int FRAME_H_W      = 13;
	localparam int CFG_DATA_W     = 13;
	localparam int OUT_ROW_W      = 12;
	localparam int OUT_COL_W      = 10;
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 4096;
	localparam int JOB_Q_DEPTH    = 2;

	localparam logic [FRAME_W_W-1:0] FRAME_W_RST = 11'd640;
	localparam logic [FRAME_H_W-1:0] FRAME_H_RST = 13'd480;

	typedef enum logic [0:0] {
		CFG_FRAME_WIDTH  = 1'b0,
		CFG_FRAME_HEIGHT = 1'b1
	} cfg_idx_t;

	// one classified pixel with the differences it needs
	typedef struct packed {
		logic [PIX_W-1:0]     dx;
		logic [PIX_W-1:0]     dy;
		logic [PIX_W-1:0]     dl;
		logic [OUT_ROW_W-1:0] row;
		logic [OUT_COL_W-1:0] col;
		logic                 has_above;
		logic                 has_left;
		logic                 has_self;
	} job_t;

endpackage

// ===== rtl/gmfd_ram.sv =====
`timescale 1ns / 1ps

module gmfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/gmfd_fifo.sv =====
`timescale 1ns / 1ps

module gmfd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] dout
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [AW:0]      cnt_q;
	logic             wr;
	logic             rd;

	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign wr    = push && !full;
	assign rd    = pop && !empty;
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (rd) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({wr, rd})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

// ===== rtl/gmfd_front.sv =====
`timescale 1ns / 1ps

module gmfd_front #(
	parameter int MAX_WIDTH  = gmfd_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = gmfd_pkg::MAX_HEIGHT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic [gmfd_pkg::PIX_W-1:0]         pixel,
	input  logic [gmfd_pkg::FRAME_W_W-1:0]     frame_width,
	input  logic [gmfd_pkg::FRAME_H_W-1:0]     frame_height,
	output logic                               job_push,
	output gmfd_pkg::job_t                     job,
	input  logic                               job_full
);

	import gmfd_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int WX = (FRAME_W_W > CW + 1) ? FRAME_W_W : CW + 1;
	localparam int HX = (FRAME_H_W > RW + 1) ? FRAME_H_W : RW + 1;
	localparam logic [WX-1:0] MAXW_X = WX'(MAX_WIDTH);
	localparam logic [HX-1:0] MAXH_X = HX'(MAX_HEIGHT);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RD_HERE,
		S_RD_RIGHT,
		S_HOLD
	} st_t;

	st_t              st_q;
	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_q;
	logic [PIX_W-1:0] prev_q;

	logic [PIX_W-1:0] px_s1;
	logic [PIX_W-1:0] prev_s1;
	logic [PIX_W-1:0] here_s1;
	logic [CW-1:0]    c_s1;
	logic [RW-1:0]    r_s1;
	logic             lc_s1;
	logic             lr_s1;

	logic             vld_s2;
	logic             right_ok_s2;
	logic [PIX_W-1:0] px_s2;
	logic [PIX_W-1:0] prev_s2;
	logic [PIX_W-1:0] here_s2;
	logic [PIX_W-1:0] right_s2;
	logic [CW-1:0]    c_s2;
	logic [RW-1:0]    r_s2;
	logic             lc_s2;
	logic             lr_s2;

	logic [WX-1:0]    fw_x;
	logic [WX-1:0]    w_last;
	logic [HX-1:0]    fh_x;
	logic [HX-1:0]    h_last;
	logic             last_col;
	logic             last_row;
	logic             acc;
	logic             adv;
	logic             s2_done;
	logic             s2_free;
	logic             any_res;
	logic             rd_en;
	logic             wr_en;
	logic [CW-1:0]    rd_addr;
	logic [PIX_W-1:0] rd_data;
	logic [PIX_W-1:0] here_cur;
	logic [PIX_W-1:0] right_cur;

	function automatic logic [PIX_W-1:0] absd(input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	// clamp the frame size to 1..max
	always_comb begin
		fw_x = WX'(frame_width);
		fh_x = HX'(frame_height);
		if (fw_x == '0) begin
			w_last = '0;
		end else if (fw_x > MAXW_X) begin
			w_last = MAXW_X - 1'b1;
		end else begin
			w_last = fw_x - 1'b1;
		end
		if (fh_x == '0) begin
			h_last = '0;
		end else if (fh_x > MAXH_X) begin
			h_last = MAXH_X - 1'b1;
		end else begin
			h_last = fh_x - 1'b1;
		end
	end

	assign last_col = (WX'(col_q) >= w_last);
	assign last_row = (HX'(row_q) >= h_last);

	assign adv  = ((st_q == S_RD_RIGHT) || (st_q == S_HOLD)) && s2_free;
	assign full = (st_q != S_IDLE) && !adv;
	assign acc  = push && !full;

	// line store: read here, then read right and write the new pixel
	assign rd_en   = (st_q != S_IDLE);
	assign wr_en   = (st_q == S_RD_RIGHT);
	assign rd_addr = ((st_q == S_RD_HERE) || lc_s1) ? c_s1 : c_s1 + 1'b1;

	gmfd_ram #(
		.WIDTH(PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_line (
		.clk   (clk),
		.we    (wr_en),
		.waddr (c_s1),
		.wdata (px_s1),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	assign here_cur  = (st_q == S_RD_RIGHT) ? rd_data : here_s1;
	assign right_cur = right_ok_s2 ? right_s2 : rd_data;

	always_comb begin
		job.dx        = lc_s2 ? '0 : absd(right_cur, here_s2);
		job.dy        = absd(px_s2, here_s2);
		job.dl        = absd(px_s2, prev_s2);
		job.row       = OUT_ROW_W'(r_s2);
		job.col       = OUT_COL_W'(c_s2);
		job.has_above = (r_s2 != '0);
		job.has_left  = lr_s2 && (c_s2 != '0);
		job.has_self  = lr_s2 && lc_s2;
	end

	assign any_res  = job.has_above || job.has_left || job.has_self;
	assign job_push = vld_s2 && any_res && !job_full;
	assign s2_done  = vld_s2 && (!any_res || !job_full);
	assign s2_free  = !vld_s2 || s2_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			prev_q      <= '0;
			vld_s2      <= 1'b0;
			right_ok_s2 <= 1'b0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (acc) begin
						st_q <= S_RD_HERE;
					end
				end
				S_RD_HERE: st_q <= S_RD_RIGHT;
				S_RD_RIGHT: begin
					if (acc) begin
						st_q <= S_RD_HERE;
					end else begin
						st_q <= adv ? S_IDLE : S_HOLD;
					end
				end
				S_HOLD: begin
					if (acc) begin
						st_q <= S_RD_HERE;
					end else if (adv) begin
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
			if (acc) begin
				prev_q <= pixel;
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			if (adv) begin
				vld_s2      <= 1'b1;
				right_ok_s2 <= 1'b0;
			end else if (s2_done) begin
				vld_s2 <= 1'b0;
			end else if (vld_s2 && !right_ok_s2) begin
				right_ok_s2 <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			px_s1   <= pixel;
			prev_s1 <= prev_q;
			c_s1    <= col_q;
			r_s1    <= row_q;
			lc_s1   <= last_col;
			lr_s1   <= last_row;
		end
		if (st_q == S_RD_RIGHT) begin
			here_s1 <= rd_data;
		end
		if (adv) begin
			px_s2   <= px_s1;
			prev_s2 <= prev_s1;
			here_s2 <= here_cur;
			c_s2    <= c_s1;
			r_s2    <= r_s1;
			lc_s2   <= lc_s1;
			lr_s2   <= lr_s1;
		end
		if (vld_s2 && !right_ok_s2) begin
			right_s2 <= rd_data;
		end
	end

endmodule

// ===== rtl/gmfd_back.sv =====
`timescale 1ns / 1ps

module gmfd_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           job_empty,
	input  gmfd_pkg::job_t                 job,
	output logic                           job_pop,
	output logic                           empty,
	input  logic                           pop,
	output logic [gmfd_pkg::MAG_W-1:0]     magnitude,
	output logic [gmfd_pkg::OUT_ROW_W-1:0] out_row,
	output logic [gmfd_pkg::OUT_COL_W-1:0] out_col,
	output logic                           last_in_run,
	output logic                           frame_done
);

	import gmfd_pkg::*;

	localparam int SQ_W     = 2 * PIX_W + 2;
	localparam int ROOT_W   = PIX_W + 1;
	localparam int REM_W    = PIX_W + 2;
	localparam int STEP_PER = 3;
	localparam int SL       = 2 * STEP_PER;

	typedef struct packed {
		logic above;
		logic left;
		logic self;
	} pend_t;

	typedef struct packed {
		logic [PIX_W-1:0]     dl;
		logic [OUT_ROW_W-1:0] row;
		logic [OUT_COL_W-1:0] col;
		pend_t                pend;
	} ctx_t;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sq_t;

	logic                 vld_s1;
	logic                 vld_s2;
	logic                 vld_s3;
	logic                 vld_s4;
	logic                 vld_s5;
	logic [SQ_W-1:0]      v_s1;
	logic [SQ_W-1:0]      v_s2;
	logic [SQ_W-1:0]      v_s3;
	sq_t                  sq_s2;
	sq_t                  sq_s3;
	logic [ROOT_W-1:0]    root_s4;
	ctx_t                 ctx_s1;
	ctx_t                 ctx_s2;
	ctx_t                 ctx_s3;
	ctx_t                 ctx_s4;
	pend_t                pend_s5;
	logic [MAG_W-1:0]     mag_s5;
	logic [PIX_W-1:0]     dl_s5;
	logic [OUT_ROW_W-1:0] row_s5;
	logic [OUT_COL_W-1:0] col_s5;

	logic                 rdy1;
	logic                 rdy2;
	logic                 rdy3;
	logic                 rdy4;
	logic                 rdy5;
	logic                 single;
	pend_t                pend_next;
	logic [2*PIX_W-1:0]   sqx;
	logic [2*PIX_W-1:0]   sqy;
	sq_t                  sq_a;
	sq_t                  sq_b;
	sq_t                  sq_c;

	// digit-by-digit integer square root, two bits of the radicand per step
	function automatic sq_t sqrt_steps(input sq_t s, input logic [SL-1:0] bits);
		sq_t              r;
		logic [REM_W+1:0] rx;
		logic [REM_W+1:0] t;
		r = s;
		for (int i = STEP_PER - 1; i >= 0; i--) begin
			rx = {r.rem, bits[2*i +: 2]};
			t  = {1'b0, r.root, 2'b01};
			if (rx >= t) begin
				r.rem  = REM_W'(rx - t);
				r.root = {r.root[ROOT_W-2:0], 1'b1};
			end else begin
				r.rem  = rx[REM_W-1:0];
				r.root = {r.root[ROOT_W-2:0], 1'b0};
			end
		end
		return r;
	endfunction

	assign single = !(pend_s5.above && (pend_s5.left || pend_s5.self)) &&
		!(pend_s5.left && pend_s5.self);

	assign rdy5    = !vld_s5 || (pop && single);
	assign rdy4    = !vld_s4 || rdy5;
	assign rdy3    = !vld_s3 || rdy4;
	assign rdy2    = !vld_s2 || rdy3;
	assign rdy1    = !vld_s1 || rdy2;
	assign job_pop = !job_empty && rdy1;

	assign sqx  = job.dx * job.dx;
	assign sqy  = job.dy * job.dy;
	assign sq_a = sqrt_steps(sq_t'('0), v_s1[SQ_W-1 -: SL]);
	assign sq_b = sqrt_steps(sq_s2, v_s2[SQ_W-1-SL -: SL]);
	assign sq_c = sqrt_steps(sq_s3, v_s3[SL-1:0]);

	always_comb begin
		pend_next = pend_s5;
		if (pend_s5.above) begin
			pend_next.above = 1'b0;
		end else if (pend_s5.left) begin
			pend_next.left = 1'b0;
		end else begin
			pend_next.self = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			pend_s5 <= '0;
		end else begin
			if (rdy1) begin
				vld_s1 <= job_pop;
			end
			if (rdy2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy3) begin
				vld_s3 <= vld_s2;
			end
			if (rdy4) begin
				vld_s4 <= vld_s3;
			end
			if (rdy5) begin
				vld_s5  <= vld_s4;
				pend_s5 <= ctx_s4.pend;
			end else if (pop) begin
				pend_s5 <= pend_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			v_s1            <= SQ_W'(sqx) + SQ_W'(sqy);
			ctx_s1.dl       <= job.dl;
			ctx_s1.row      <= job.row;
			ctx_s1.col      <= job.col;
			ctx_s1.pend     <= {job.has_above, job.has_left, job.has_self};
		end
		if (rdy2) begin
			sq_s2  <= sq_a;
			v_s2   <= v_s1;
			ctx_s2 <= ctx_s1;
		end
		if (rdy3) begin
			sq_s3  <= sq_b;
			v_s3   <= v_s2;
			ctx_s3 <= ctx_s2;
		end
		if (rdy4) begin
			root_s4 <= sq_c.root;
			ctx_s4  <= ctx_s3;
		end
		if (rdy5) begin
			mag_s5 <= root_s4[ROOT_W-1] ? '1 : root_s4[MAG_W-1:0];
			dl_s5  <= ctx_s4.dl;
			row_s5 <= ctx_s4.row;
			col_s5 <= ctx_s4.col;
		end
	end

	// results of one pixel in order: above, left, self
	assign empty       = !vld_s5;
	assign magnitude   = pend_s5.above ? mag_s5 : (pend_s5.left ? dl_s5 : '0);
	assign out_row     = pend_s5.above ? row_s5 - 1'b1 : row_s5;
	assign out_col     = (!pend_s5.above && pend_s5.left) ? col_s5 - 1'b1 : col_s5;
	assign last_in_run = single;
	assign frame_done  = !pend_s5.above && !pend_s5.left;

endmodule

// ===== rtl/gradient_magnitude_forward_diff_core.sv =====
`timescale 1ns / 1ps

// Forward-difference gradient magnitude over a raster stream of 8-bit pixels.
// Input: drive pixel with push; the pixel is taken on an edge where push is
// high and full is low. Results: while empty is low the oldest result sits on
// magnitude, out_row, out_col, last_in_run and frame_done; pop takes it.
// Config: frame_width (index 0) and frame_height (index 1) are written on an
// edge with cfg_valid high; cfg_ready is always high. Write only when idle.
// A pixel's result leaves when the pixel below it arrives; last-row results
// leave with the pixel to the right or at the end of the row, so one pixel
// gives up to three results, emitted one per cycle while pop is high.
// Each pixel makes two line-memory reads on the single read port, so full
// stays high while the first read of a taken pixel is made. A result passes
// the front stages, the job queue and the back stages s1 to s5 to the ports.
// When pop is held low the result pipe and the job queue fill and full rises;
// nothing is dropped.
// Reset: position goes to row 0 column 0, previous pixel to 0, width to 640
// and height to 480; the line memory is not cleared.
module gradient_magnitude_forward_diff_core #(
	parameter int MAX_WIDTH  = gmfd_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = gmfd_pkg::MAX_HEIGHT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [gmfd_pkg::PIX_W-1:0]      pixel,
	output logic                            empty,
	input  logic                            pop,
	output logic [gmfd_pkg::MAG_W-1:0]      magnitude,
	output logic [gmfd_pkg::OUT_ROW_W-1:0]  out_row,
	output logic [gmfd_pkg::OUT_COL_W-1:0]  out_col,
	output logic                            last_in_run,
	output logic                            frame_done,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  gmfd_pkg::cfg_idx_t              cfg_index,
	input  logic [gmfd_pkg::CFG_DATA_W-1:0] cfg_data
);

	import gmfd_pkg::*;

	localparam int JOB_W = $bits(job_t);

	logic [FRAME_W_W-1:0] fw_q;
	logic [FRAME_H_W-1:0] fh_q;
	job_t                 front_job;
	job_t                 back_job;
	logic                 job_push;
	logic                 job_full;
	logic                 job_pop;
	logic                 job_empty;
	logic [JOB_W-1:0]     q_dout;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= FRAME_W_RST;
			fh_q <= FRAME_H_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FRAME_WIDTH: fw_q <= cfg_data[FRAME_W_W-1:0];
				CFG_FRAME_HEIGHT: fh_q <= cfg_data[FRAME_H_W-1:0];
				default: ;
			endcase
		end
	end

	gmfd_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.pixel        (pixel),
		.frame_width  (fw_q),
		.frame_height (fh_q),
		.job_push     (job_push),
		.job          (front_job),
		.job_full     (job_full)
	);

	gmfd_fifo #(
		.WIDTH (JOB_W),
		.DEPTH (JOB_Q_DEPTH)
	) u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.full   (job_full),
		.din    (front_job),
		.pop    (job_pop),
		.empty  (job_empty),
		.dout   (q_dout)
	);

	assign back_job = job_t'(q_dout);

	gmfd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_empty   (job_empty),
		.job         (back_job),
		.job_pop     (job_pop),
		.empty       (empty),
		.pop         (pop),
		.magnitude   (magnitude),
		.out_row     (out_row),
		.out_col     (out_col),
		.last_in_run (last_in_run),
		.frame_done  (frame_done)
	);

endmodule

// ===== test/gmfd_gradient_checker.sv =====
`timescale 1ns / 1ps

module gmfd_gradient_checker #(
	parameter int MAX_WIDTH  = gmfd_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = gmfd_pkg::MAX_HEIGHT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  logic                            full,
	input  logic [gmfd_pkg::PIX_W-1:0]      pixel,
	input  logic                            empty,
	input  logic                            pop,
	input  logic [gmfd_pkg::MAG_W-1:0]      magnitude,
	input  logic [gmfd_pkg::OUT_ROW_W-1:0]  out_row,
	input  logic [gmfd_pkg::OUT_COL_W-1:0]  out_col,
	input  logic                            last_in_run,
	input  logic                            frame_done,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  gmfd_pkg::cfg_idx_t              cfg_index,
	input  logic [gmfd_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              fail_count,
	output int                              pending,
	output int                              results_seen
);

	import gmfd_pkg::*;

	typedef struct packed {
		logic [MAG_W-1:0]     mag;
		logic [OUT_ROW_W-1:0] row;
		logic [OUT_COL_W-1:0] col;
		logic                 last;
		logic                 done;
	} grad_result_t;

	grad_result_t         expected_grad[$];
	logic [PIX_W-1:0]     line_mem [0:MAX_WIDTH-1];
	logic [PIX_W-1:0]     prev_pix;
	int                   row_pos;
	int                   col_pos;
	logic [FRAME_W_W-1:0] width_reg;
	logic [FRAME_H_W-1:0] height_reg;

	function automatic int pix_diff(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
		return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
	endfunction

	function automatic logic [MAG_W-1:0] floor_root_sat(int dx, int dy);
		int sum_sq;
		int root;
		int trial;
		sum_sq = dx * dx + dy * dy;
		root = 0;
		for (int b = 9; b >= 0; b--) begin
			trial = root | (1 << b);
			if (trial * trial <= sum_sq)
				root = trial;
		end
		return (root > 255) ? 8'd255 : root[MAG_W-1:0];
	endfunction

	function automatic void report(string what, grad_result_t want, grad_result_t got);
		fail_count++;
		if (fail_count <= 10) begin
			$write("%s: expected mag %0d row %0d col %0d last %0b done %0b, ",
				what, want.mag, want.row, want.col, want.last, want.done);
			$display("got mag %0d row %0d col %0d last %0b done %0b",
				got.mag, got.row, got.col, got.last, got.done);
		end
	endfunction

	task automatic predict_gradients(input logic [PIX_W-1:0] px);
		int               w;
		int               h;
		int               r;
		int               c;
		int               dx;
		int               first_new;
		bit               at_last_col;
		bit               at_last_row;
		logic [PIX_W-1:0] here;
		grad_result_t     res;
		w = int'(width_reg);
		h = int'(height_reg);
		if (w < 1) w = 1;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		if (h < 1) h = 1;
		if (h > MAX_HEIGHT) h = MAX_HEIGHT;
		r = row_pos;
		c = col_pos;
		if (c >= MAX_WIDTH) c = MAX_WIDTH - 1;
		at_last_col = (c >= w - 1);
		at_last_row = (r >= h - 1);
		first_new = expected_grad.size();
		// pixel above is complete now that the one below has arrived
		if (r > 0) begin
			here = line_mem[c];
			dx = at_last_col ? 0 : pix_diff(line_mem[c + 1], here);
			res = {floor_root_sat(dx, pix_diff(px, here)), 12'(r - 1), 10'(c), 1'b0, 1'b0};
			expected_grad.push_back(res);
		end
		if (at_last_row && c > 0) begin
			res = {floor_root_sat(pix_diff(px, prev_pix), 0), 12'(r), 10'(c - 1), 1'b0, 1'b0};
			expected_grad.push_back(res);
		end
		if (at_last_row && at_last_col) begin
			res = {8'd0, 12'(r), 10'(c), 1'b0, 1'b1};
			expected_grad.push_back(res);
		end
		if (expected_grad.size() > first_new)
			expected_grad[expected_grad.size() - 1].last = 1'b1;
		line_mem[c] = px;
		prev_pix = px;
		if (at_last_col) begin
			col_pos = 0;
			row_pos = at_last_row ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
		end
	endtask

	task automatic check_result();
		grad_result_t got;
		grad_result_t want;
		got = {magnitude, out_row, out_col, last_in_run, frame_done};
		results_seen++;
		if (expected_grad.size() == 0) begin
			want = 'x;
			report("result with nothing expected", want, got);
		end else begin
			want = expected_grad.pop_front();
			if (got !== want)
				report("result mismatch", want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_grad.delete();
			prev_pix = '0;
			row_pos = 0;
			col_pos = 0;
			width_reg = FRAME_W_RST;
			height_reg = FRAME_H_RST;
			fail_count = 0;
			results_seen = 0;
			pending <= 0;
		end else begin
			if (pop && !empty)
				check_result();
			if (push && !full)
				predict_gradients(pixel);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_FRAME_WIDTH: width_reg = cfg_data[FRAME_W_W-1:0];
					CFG_FRAME_HEIGHT: height_reg = cfg_data[FRAME_H_W-1:0];
					default: ;
				endcase
			end
			pending <= expected_grad.size();
		end
	end

endmodule

// ===== test/tb_gradient_magnitude_forward_diff_core.sv =====
`timescale 1ns / 1ps

module tb_gradient_magnitude_forward_diff_core;

	import gmfd_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 40;

	logic                  clk;
	logic                  arst_n;
	logic                  push;
	logic                  full;
	logic [PIX_W-1:0]      pixel;
	logic                  empty;
	logic                  pop;
	logic [MAG_W-1:0]      magnitude;
	logic [OUT_ROW_W-1:0]  out_row;
	logic [OUT_COL_W-1:0]  out_col;
	logic                  last_in_run;
	logic                  frame_done;
	logic                  cfg_valid;
	logic                  cfg_ready;
	cfg_idx_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int fail_count;
	int pending;
	int results_seen;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_req;
	int eff_w;
	int eff_h;
	int stim_col;
	int stim_row;
	int pixels_sent;
	int reg_writes;

	gradient_magnitude_forward_diff_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.pixel      (pixel),
		.empty      (empty),
		.pop        (pop),
		.magnitude  (magnitude),
		.out_row    (out_row),
		.out_col    (out_col),
		.last_in_run(last_in_run),
		.frame_done (frame_done),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	gmfd_gradient_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.pixel       (pixel),
		.empty       (empty),
		.pop         (pop),
		.magnitude   (magnitude),
		.out_row     (out_row),
		.out_col     (out_col),
		.last_in_run (last_in_run),
		.frame_done  (frame_done),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.pending     (pending),
		.results_seen(results_seen)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	// result side, with an occasional long hold-off
	initial begin
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				pop <= 1'b0;
				for (int n = 1; n < HOLD_CYCLES; n++)
					@(posedge clk);
			end else begin
				pop <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	task automatic set_mode(input int mode);
		case (mode)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
			default: begin send_idle_pct = 34; recv_stall_pct = 34; end
		endcase
	endtask

	function automatic logic [PIX_W-1:0] rand_pixel();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			default: return PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_pixel(input logic [PIX_W-1:0] px);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		pixel <= px;
		do
			@(posedge clk);
		while (full);
		pixels_sent++;
		if (stim_col >= eff_w - 1) begin
			stim_col = 0;
			stim_row = (stim_row >= eff_h - 1) ? 0 : stim_row + 1;
		end else begin
			stim_col++;
		end
	endtask

	task automatic write_reg(input cfg_idx_t idx, input int value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		reg_writes++;
		if (idx == CFG_FRAME_WIDTH)
			eff_w = (value < 1) ? 1 : (value > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : value;
		else
			eff_h = (value < 1) ? 1 : (value > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : value;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		bit cut_short;
		int sent;
		arst_n = 1'b0;
		push = 1'b0;
		pixel = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_FRAME_WIDTH;
		cfg_data = '0;
		hold_req = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		eff_w = 640;
		eff_h = 480;
		stim_col = 0;
		stim_row = 0;
		pixels_sent = 0;
		reg_writes = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset geometry, row 0 only, then shrink both mid-frame
		set_mode(0);
		send_pixel(8'd0);
		send_pixel(8'd255);
		send_pixel(8'h5a);
		wait_idle();
		write_reg(CFG_FRAME_WIDTH, 4);
		write_reg(CFG_FRAME_HEIGHT, 1);
		send_pixel(8'ha5);
		wait_idle();

		// zero registers act as one pixel frames
		set_mode(1);
		write_reg(CFG_FRAME_WIDTH, 0);
		write_reg(CFG_FRAME_HEIGHT, 0);
		send_pixel(8'd0);
		send_pixel(8'd255);
		wait_idle();

		// 2x2 frames with saturating magnitude
		set_mode(2);
		write_reg(CFG_FRAME_WIDTH, 2);
		write_reg(CFG_FRAME_HEIGHT, 2);
		send_pixel(8'd0);
		send_pixel(8'd255);
		send_pixel(8'd255);
		send_pixel(8'd0);
		send_pixel(8'd255);
		send_pixel(8'd0);
		send_pixel(8'd0);
		send_pixel(8'd255);
		wait_idle();

		// oversize width on a single row, cut short
		set_mode(3);
		write_reg(CFG_FRAME_WIDTH, 2047);
		write_reg(CFG_FRAME_HEIGHT, 1);
		send_pixel(8'h80);
		send_pixel(8'h7f);
		send_pixel(8'h01);
		send_pixel(8'hfe);
		send_pixel(8'h33);
		wait_idle();
		write_reg(CFG_FRAME_WIDTH, 3);
		send_pixel(8'hcc);
		wait_idle();

		// oversize height on a single column, cut short
		set_mode(0);
		write_reg(CFG_FRAME_WIDTH, 1);
		write_reg(CFG_FRAME_HEIGHT, 8191);
		send_pixel(8'h10);
		send_pixel(8'hf0);
		send_pixel(8'h0f);
		send_pixel(8'h99);
		wait_idle();
		write_reg(CFG_FRAME_HEIGHT, 2);
		send_pixel(8'h66);
		wait_idle();

		for (int ph = 0; ph < 8; ph++) begin
			set_mode(ph % 4);
			write_reg(CFG_FRAME_WIDTH, $urandom_range(1, 12));
			write_reg(CFG_FRAME_HEIGHT, $urandom_range(1, 6));
			cut_short = ($urandom_range(0, 3) == 0);
			if (ph == 4)
				hold_req = 1'b1;
			sent = 0;
			while (sent < 22 || stim_col != 0 || stim_row != 0) begin
				send_pixel(rand_pixel());
				sent++;
				if (cut_short && sent >= 16 && (stim_col != 0 || stim_row != 0)) begin
					// shrink geometry mid-frame, never growing it
					cut_short = 1'b0;
					wait_idle();
					if ($urandom_range(0, 1))
						write_reg(CFG_FRAME_WIDTH, $urandom_range(1, eff_w));
					else
						write_reg(CFG_FRAME_HEIGHT, $urandom_range(1, eff_h));
				end
			end
			wait_idle();
		end

		$display("covered %0d pixels and %0d checked results over %0d register writes",
			pixels_sent, results_seen, reg_writes);
		$display("geometries included zero, oversize and mid-frame shrinks, with stalls on both sides");
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/gmfd_pkg.sv
rtl/gmfd_ram.sv
rtl/gmfd_fifo.sv
rtl/gmfd_front.sv
rtl/gmfd_back.sv
rtl/gradient_magnitude_forward_diff_core.sv
test/gmfd_gradient_checker.sv
test/tb_gradient_magnitude_forward_diff_core.sv
